/* rtl/core/hcwp_pkg.sv */
// Shared types and constants for the code word packer.
`timescale 1ns / 1ps

package hcwp_pkg;

    // Packed word width and widths derived from it
    localparam int WORD_BITS = 32;
    localparam int FILL_W    = $clog2(WORD_BITS);
    localparam int LEN_W     = $clog2(WORD_BITS + 1);

    // Input field widths
    localparam int SYM_W     = 7;
    localparam int CODE_LEN_W = 6;

    // Default table size and end symbol after reset
    localparam int SYMBOL_COUNT_DEF = 128;
    localparam logic [SYM_W-1:0] END_SYMBOL_RST = 7'd3;

    // Output queue depth
    localparam int OUT_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FINISH = 2'd2
    } t_req;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_FINISH = 1'b1
    } t_pack_op;

    typedef struct packed {
        t_req                  req_type;
        logic [SYM_W-1:0]      symbol;
        logic [CODE_LEN_W-1:0] code_length;
        logic [WORD_BITS-1:0]  code_bits;
    } t_in_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] out_word;
        logic                 last_word;
    } t_out_item;

    typedef struct packed {
        logic [LEN_W-1:0]     len;
        logic [WORD_BITS-1:0] bits;
    } t_entry;

    // Words produced by the packer in one cycle, first in word0
    typedef struct packed {
        logic [1:0] count;
        t_out_item  word0;
        t_out_item  word1;
    } t_pack_res;

endpackage

/* rtl/core/hcwp_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module hcwp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/hcwp_pack.sv */
// Bit accumulator: appends one code per cycle and flushes on finish.
`timescale 1ns / 1ps

module hcwp_pack
    import hcwp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_pack_op  i_op,
    input  logic      i_hit,
    input  t_entry    i_entry,
    output t_pack_res o_res
);

    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [FILL_W-1:0]    r_fill, n_fill;

    logic [LEN_W-1:0]     len;
    logic [LEN_W:0]       total;
    logic [LEN_W-1:0]     hi;
    logic [LEN_W-1:0]     rem;
    logic [LEN_W-1:0]     pad;
    logic                 fired;
    logic [WORD_BITS-1:0] word_a;
    logic [WORD_BITS-1:0] acc_a;
    logic [FILL_W-1:0]    fill_a;
    t_out_item            tail;

    // Append the looked-up code to the accumulator
    always_comb begin
        len    = i_hit ? i_entry.len : '0;
        total  = {1'b0, len} + (LEN_W + 1)'(r_fill);
        hi     = LEN_W'(WORD_BITS) - LEN_W'(r_fill);
        rem    = len - hi;
        fired  = 1'b0;
        word_a = '0;
        acc_a  = r_acc;
        fill_a = r_fill;
        if (len != '0) begin
            if (total < (LEN_W + 1)'(WORD_BITS)) begin
                acc_a  = (r_acc << len) | i_entry.bits;
                fill_a = FILL_W'(total);
            end else begin
                word_a = (r_acc << hi) | (i_entry.bits >> rem);
                acc_a  = i_entry.bits & ~({WORD_BITS{1'b1}} << rem);
                fill_a = FILL_W'(rem);
                fired  = 1'b1;
            end
        end
        pad = LEN_W'(WORD_BITS) - LEN_W'(fill_a);
        tail.out_word  = acc_a << pad;
        tail.last_word = 1'b1;
    end

    // Order the produced words and pick the next accumulator state
    always_comb begin
        o_res.count           = 2'd0;
        o_res.word0.out_word  = word_a;
        o_res.word0.last_word = 1'b0;
        o_res.word1           = tail;
        n_acc                 = r_acc;
        n_fill                = r_fill;
        if (i_valid) begin
            if (i_op == OP_FINISH) begin
                n_acc  = '0;
                n_fill = '0;
                if (fired) begin
                    o_res.word0.last_word = (fill_a == '0);
                    o_res.count = (fill_a != '0) ? 2'd2 : 2'd1;
                end else if (fill_a != '0) begin
                    o_res.word0 = tail;
                    o_res.count = 2'd1;
                end
            end else begin
                n_acc       = acc_a;
                n_fill      = fill_a;
                o_res.count = {1'b0, fired};
            end
        end
    end

    // Hold the accumulator and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fill <= '0;
        end else begin
            r_acc  <= n_acc;
            r_fill <= n_fill;
        end
    end

endmodule

/* rtl/core/huffman_code_word_packer_core.sv */
// Top level: code table lookup, bit packing and output word queue.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data
//  out     | output    | o_out_valid / i_out_ready | o_out_data
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_wdata
//
// One item per cycle while o_in_ready is high: the table read of an accepted
// item lands in the packer in the next cycle, and its words enter a 4-deep
// output queue the cycle after that, from which they reach the port.
// Input ready depends on free queue slots, reserving two per finish and
// one per encode still in the packer; a stalled output fills the queue.
// Synchronous reset clears the accumulator and queue and sets the end symbol to 3;
// the code table is not cleared and must be loaded before use.
`timescale 1ns / 1ps

module huffman_code_word_packer_core
    import hcwp_pkg::*;
#(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [SYM_W-1:0] i_cfg_wdata
);

    localparam int ADDR_W = $clog2(SYMBOL_COUNT);
    localparam int PTR_W  = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W  = PTR_W + 2;

    logic [SYM_W-1:0] r_end_symbol;

    logic              in_xfer;
    logic [SYM_W-1:0]  rd_sym;
    logic              rd_hit;
    logic              wr_hit;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    t_entry            wr_entry;
    t_entry            rd_entry;
    logic [LEN_W-1:0]  len_sat;

    logic     r_s1_valid;
    t_pack_op r_s1_op;
    logic     r_s1_hit;

    t_pack_res pack_res;

    t_out_item        r_fifo [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] reserve;
    logic             out_xfer;

    // Hold the end symbol register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_symbol <= END_SYMBOL_RST;
        end else if (i_cfg_we) begin
            r_end_symbol <= i_cfg_wdata;
        end
    end

    // Decode the input transfer into a table write or a table read
    assign in_xfer = i_in_valid && o_in_ready;
    assign rd_sym  = (i_in_data.req_type == REQ_FINISH) ? r_end_symbol : i_in_data.symbol;
    assign rd_hit  = int'(rd_sym) < SYMBOL_COUNT;
    assign wr_hit  = int'(i_in_data.symbol) < SYMBOL_COUNT;

    always_comb begin
        if (int'(i_in_data.code_length) > WORD_BITS) begin
            len_sat = LEN_W'(WORD_BITS);
        end else begin
            len_sat = LEN_W'(i_in_data.code_length);
        end
        wr_entry.len  = len_sat;
        wr_entry.bits = i_in_data.code_bits & ~({WORD_BITS{1'b1}} << len_sat);
    end

    assign ram_we    = in_xfer && (i_in_data.req_type == REQ_LOAD) && wr_hit;
    assign ram_waddr = ADDR_W'(i_in_data.symbol);
    assign ram_raddr = ADDR_W'(rd_sym);

    hcwp_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    // Advance encode and finish items into the packer stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_op    <= OP_ENCODE;
            r_s1_hit   <= 1'b0;
        end else begin
            r_s1_valid <= in_xfer && ((i_in_data.req_type == REQ_ENCODE)
                                   || (i_in_data.req_type == REQ_FINISH));
            r_s1_op    <= (i_in_data.req_type == REQ_FINISH) ? OP_FINISH : OP_ENCODE;
            r_s1_hit   <= rd_hit;
        end
    end

    hcwp_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_op    (r_s1_op),
        .i_hit   (r_s1_hit),
        .i_entry (rd_entry),
        .o_res   (pack_res)
    );

    // Reserve queue room for the item in the packer and the next one
    always_comb begin
        reserve = '0;
        if (r_s1_valid) begin
            reserve = (r_s1_op == OP_FINISH) ? CNT_W'(2) : CNT_W'(1);
        end
    end

    assign o_in_ready = (r_count + reserve) <= CNT_W'(OUT_FIFO_DEPTH - 2);

    // Output queue: push up to two words, pop one per transfer
    assign out_xfer    = o_out_valid && i_out_ready;
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (pack_res.count != 2'd0) begin
            r_fifo[r_wr_ptr] <= pack_res.word0;
        end
        if (pack_res.count == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= pack_res.word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(pack_res.count);
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(pack_res.count) - CNT_W'(out_xfer);
        end
    end

`ifndef SYNTHESIS
    // Queue never holds more words than it has slots
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUT_FIFO_DEPTH))
        else $error("output queue overflow");

    // Packer output always finds room in the queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pack_res.count != 2'd0) |->
            (r_count + CNT_W'(pack_res.count)) <= CNT_W'(OUT_FIFO_DEPTH))
        else $error("packer pushed into a full queue");

    // Only encode and finish items reach the packer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.req_type == REQ_LOAD)) |=> !r_s1_valid)
        else $error("load item entered the packer stage");

    // At most one word leaves the packer for an encode item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_op == OP_ENCODE)) |-> (pack_res.count != 2'd2))
        else $error("encode produced two words");
`endif

endmodule

/* tb/hcwp_word_checker.sv */
// Checker for the code word packer: predicts packed words from input transfers and checks them.
`timescale 1ns / 1ps

module hcwp_word_checker
    import hcwp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out_data,
    input  logic             i_cfg_we,
    input  logic [SYM_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_words_pending,
    output int               o_words_checked,
    output int               o_last_words
);

    localparam int TABLE_DEPTH = SYMBOL_COUNT_DEF;
    localparam int REPORT_MAX  = 10;

    // Shadow copy of the code table and the packing state
    logic [CODE_LEN_W-1:0] code_len_tbl [TABLE_DEPTH];
    logic [WORD_BITS-1:0]  code_val_tbl [TABLE_DEPTH];
    logic [WORD_BITS-1:0]  pack_acc;
    int unsigned           pack_fill;
    logic [SYM_W-1:0]      end_sym;
    t_out_item             expected_words [$];
    int                    fails;
    int                    checked;
    int                    lasts;

    function automatic logic [63:0] low_bits_mask(input int unsigned n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    // Append the code of one symbol; return 1 with the full word when the accumulator fills
    function automatic bit append_sym_code(input logic [SYM_W-1:0] sym,
                                           output logic [WORD_BITS-1:0] word);
        int unsigned len;
        int unsigned total;
        int unsigned hi;
        int unsigned rem;
        logic [63:0] bits;
        logic [63:0] wide;
        logic [63:0] keep;
        len  = 32'(code_len_tbl[sym]);
        bits = {32'b0, code_val_tbl[sym]};
        word = '0;
        if (len == 0)
            return 1'b0;
        total = pack_fill + len;
        if (total < WORD_BITS) begin
            wide      = ({32'b0, pack_acc} << len) | bits;
            pack_acc  = wide[WORD_BITS-1:0];
            pack_fill = total;
            return 1'b0;
        end
        // Fill the word with the high part, spill the low part into the next word
        hi        = WORD_BITS - pack_fill;
        rem       = len - hi;
        wide      = ({32'b0, pack_acc} << hi) | (bits >> rem);
        word      = wide[WORD_BITS-1:0];
        keep      = bits & low_bits_mask(rem);
        pack_acc  = keep[WORD_BITS-1:0];
        pack_fill = rem;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out_item             got;
        t_out_item             want;
        logic [WORD_BITS-1:0]  word;
        int unsigned           load_len;
        logic [63:0]           keep;
        if (!i_rst_n) begin
            pack_acc  = '0;
            pack_fill = 0;
            end_sym   = END_SYMBOL_RST;
            expected_words.delete();
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                code_len_tbl[k] = '0;
                code_val_tbl[k] = '0;
            end
        end else begin
            if (i_cfg_we)
                end_sym = i_cfg_wdata;

            // Compare each output transfer with the oldest expected word
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("unexpected word %h last %0b with nothing pending",
                                 got.out_word, got.last_word);
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (want.last_word)
                        lasts++;
                    if (got.out_word !== want.out_word || got.last_word !== want.last_word) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("word %0d: expected %h last %0b, got %h last %0b",
                                     checked, want.out_word, want.last_word,
                                     got.out_word, got.last_word);
                    end
                end
            end

            // Advance the shadow packer on each input transfer
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.req_type)
                    REQ_LOAD: begin
                        load_len = (i_in_data.code_length > WORD_BITS) ? WORD_BITS
                                                                       : i_in_data.code_length;
                        keep = {32'b0, i_in_data.code_bits} & low_bits_mask(load_len);
                        code_len_tbl[i_in_data.symbol] = CODE_LEN_W'(load_len);
                        code_val_tbl[i_in_data.symbol] = keep[WORD_BITS-1:0];
                    end
                    REQ_ENCODE: begin
                        if (append_sym_code(i_in_data.symbol, word))
                            expected_words.push_back('{out_word: word, last_word: 1'b0});
                    end
                    REQ_FINISH: begin
                        if (append_sym_code(end_sym, word))
                            expected_words.push_back('{out_word: word,
                                                       last_word: (pack_fill == 0)});
                        if (pack_fill != 0)
                            expected_words.push_back('{out_word: pack_acc << (WORD_BITS - pack_fill),
                                                       last_word: 1'b1});
                        pack_acc  = '0;
                        pack_fill = 0;
                    end
                    default: ; // drop the unused request code
                endcase
            end
        end
        o_fail_count    <= fails;
        o_words_pending <= expected_words.size();
        o_words_checked <= checked;
        o_last_words    <= lasts;
    end

endmodule

/* tb/tb.sv */
// Testbench top: clock, reset, stimulus and verdict for the code word packer.
`timescale 1ns / 1ps

module tb;
    import hcwp_pkg::*;

    localparam int         CLK_HALF_NS     = 6;
    localparam int         RESET_CYCLES    = 3;
    localparam int         RANDOM_ITEMS    = 1050;
    localparam int         STALL_LIMIT     = 3000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         TABLE_DEPTH     = SYMBOL_COUNT_DEF;
    localparam logic [1:0] REQ_UNUSED      = 2'd3;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_item         in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_data;
    logic             cfg_we    = 1'b0;
    logic [SYM_W-1:0] cfg_wdata = '0;

    int fail_count;
    int words_pending;
    int words_checked;
    int last_words;
    int idle_cycles   = 0;
    int hold_requests = 0;
    int useful_items  = 0;
    int end_writes    = 0;
    bit no_gaps       = 1'b0;

    huffman_code_word_packer_core #(
        .SYMBOL_COUNT(SYMBOL_COUNT_DEF)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    hcwp_word_checker word_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_words_pending(words_pending),
        .o_words_checked(words_checked),
        .o_last_words   (last_words)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // End the run when no transfer happens for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CODE_LEN_W-1:0] pick_code_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return CODE_LEN_W'($urandom_range(1, 12));
        if (r < 75)
            return CODE_LEN_W'($urandom_range(13, 31));
        if (r < 82)
            return CODE_LEN_W'(WORD_BITS);
        if (r < 90)
            return '0;
        return CODE_LEN_W'($urandom_range(33, 63));
    endfunction

    // Fields a request does not use carry random junk
    function automatic t_in_item make_item(input t_req req, input logic [SYM_W-1:0] sym,
                                           input logic [CODE_LEN_W-1:0] len,
                                           input logic [WORD_BITS-1:0] bits);
        t_in_item item;
        item.req_type    = req;
        item.symbol      = sym;
        item.code_length = len;
        item.code_bits   = bits;
        return item;
    endfunction

    function automatic t_in_item encode_item(input logic [SYM_W-1:0] sym);
        return make_item(REQ_ENCODE, sym, CODE_LEN_W'($urandom), $urandom);
    endfunction

    function automatic t_in_item finish_item();
        return make_item(REQ_FINISH, SYM_W'($urandom), CODE_LEN_W'($urandom), $urandom);
    endfunction

    function automatic t_in_item unused_item();
        return make_item(t_req'(REQ_UNUSED), SYM_W'($urandom), CODE_LEN_W'($urandom),
                         $urandom);
    endfunction

    function automatic t_in_item random_load(input logic [SYM_W-1:0] sym);
        return make_item(REQ_LOAD, sym, pick_code_len(), $urandom);
    endfunction

    // Output side: random stalls, plus a long hold-off on request
    initial begin : out_side
        int holds_done;
        int span;
        holds_done = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                span = pick_gap();
                if (span != 0) begin
                    out_ready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Offer one item, hold it until the transfer, then maybe leave a gap
    task automatic send_item(input t_in_item item);
        int gap;
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (item.req_type != t_req'(REQ_UNUSED))
            useful_items++;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected word is out and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_end_symbol(input logic [SYM_W-1:0] sym);
        settle();
        cfg_wdata <= sym;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        end_writes++;
    endtask

    initial begin : stimulus
        int phase;
        int stream_len;
        int r;
        int goal;
        bit pressure;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: table extremes, exact word fills, straddles and finish cases
        send_item(make_item(REQ_LOAD, 7'd3, 6'd5, 32'hFFFF_FFF6));     // stray high bits
        send_item(make_item(REQ_LOAD, 7'd0, 6'd32, 32'h8000_0001));
        send_item(make_item(REQ_LOAD, 7'd127, 6'd63, 32'hFFFF_FFFF));  // saturates to 32
        send_item(make_item(REQ_LOAD, 7'd1, 6'd0, 32'hDEAD_BEEF));     // zero-length code
        send_item(make_item(REQ_LOAD, 7'd2, 6'd1, 32'h0000_0001));
        send_item(make_item(REQ_LOAD, 7'd4, 6'd31, 32'h5555_5555));
        send_item(make_item(REQ_LOAD, 7'd6, 6'd27, 32'h0AAA_AAAA));
        send_item(unused_item());
        send_item(encode_item(7'd1));
        send_item(encode_item(7'd0));
        send_item(encode_item(7'd2));
        send_item(encode_item(7'd127));
        send_item(encode_item(7'd4));
        send_item(encode_item(7'd2));
        send_item(encode_item(7'd4));
        send_item(finish_item());
        send_item(finish_item());
        send_item(encode_item(7'd6));
        send_item(finish_item());                                       // end code fills exactly

        // Empty end code: finish with nothing pending, then with one bit pending
        write_end_symbol(7'd1);
        send_item(finish_item());
        send_item(encode_item(7'd2));
        send_item(finish_item());

        // Full-width end code straddles the word boundary
        write_end_symbol(7'd127);
        repeat (3) send_item(encode_item(7'd2));
        send_item(finish_item());
        write_end_symbol(7'd0);

        // Random: fill the whole table, then streams with random content
        goal = useful_items + RANDOM_ITEMS;
        for (int s = 0; s < TABLE_DEPTH; s++)
            send_item(random_load(SYM_W'(s)));
        phase = 0;
        while (useful_items < goal) begin
            phase++;
            pressure = (phase == 4 || phase == 11);
            if (phase % 3 == 0 || pressure)
                write_end_symbol(SYM_W'($urandom_range(0, TABLE_DEPTH - 1)));
            no_gaps = pressure || ($urandom_range(0, 3) == 0);
            if (pressure) begin
                hold_requests <= hold_requests + 1;
                stream_len = 80;
            end else if ($urandom_range(0, 9) == 0) begin
                stream_len = $urandom_range(40, 120);
            end else begin
                stream_len = $urandom_range(0, 25);
            end
            for (int n = 0; n < stream_len; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_item(random_load(SYM_W'($urandom_range(0, TABLE_DEPTH - 1))));
                else if (r < 7)
                    send_item(unused_item());
                else
                    send_item(encode_item(SYM_W'($urandom_range(0, TABLE_DEPTH - 1))));
            end
            // Most streams end cleanly; some run on into the next phase
            if ($urandom_range(0, 9) != 0)
                send_item(finish_item());
            if ($urandom_range(0, 4) == 0)
                send_item(finish_item());
        end
        no_gaps = 1'b0;
        send_item(finish_item());
        settle();

        $display("Sent %0d items in %0d random phases with %0d end symbol writes",
                 useful_items, phase, end_writes);
        $display("Held off the output %0d times; checked %0d packed words, %0d closing a stream",
                 hold_requests, words_checked, last_words);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* huffman_code_word_packer_core.f */
rtl/core/hcwp_pkg.sv
rtl/core/hcwp_ram.sv
rtl/core/hcwp_pack.sv
rtl/core/huffman_code_word_packer_core.sv
tb/hcwp_word_checker.sv
tb/tb.sv
